@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/eiv3_pkg.sv @@
// types and constants of the ease-in vector interpolator
`default_nettype none
package eiv3_pkg;

  localparam int CW        = 32;              // coordinate bits, signed Q16.16
  localparam int AF        = 16;              // alpha fraction bits
  localparam int ALPHA_W   = AF + 1;
  localparam int RATE_W    = 24;
  localparam int DT_W      = 24;
  localparam int OP_W      = 2;
  localparam int FQ        = 16;              // factor fraction bits
  localparam int SUM_W     = 2 * CW + 2;      // sum of three squares
  localparam int DIST_W    = SUM_W / 2;       // root width
  localparam int SQ_ITERS  = SUM_W / 2;
  localparam int SREM_W    = DIST_W + 3;
  localparam int FACT_W    = DIST_W + FQ;
  localparam int RD_W      = RATE_W + DT_W;
  localparam int ACC_W     = RD_W + FACT_W;
  localparam int INC_SH    = 64 - AF;
  localparam int INC_W     = ACC_W - INC_SH;
  localparam int MUL_W     = 32;
  localparam int CNT_W     = 6;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE    = ALPHA_W'(1) << AF;
  localparam logic [FACT_W-1:0]  FACTOR_FLOOR = FACT_W'(6554);
  localparam logic [FACT_W-1:0]  FACTOR_CAP   = FACT_W'(1) << (CW + FQ);
  localparam logic [RATE_W-1:0]  RATE_RESET   = RATE_W'(65536);

  localparam logic REG_ALPHA_RATE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK, OP_RETARGET, OP_CLEAR, OP_NOP
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_MUL, ST_SQ_ADD, ST_SQRT, ST_DIV, ST_RATE_MUL, ST_RATE_LD,
    ST_PP_MUL, ST_PP_ADD, ST_INC, ST_LERP_MUL, ST_LERP_ADD, ST_FIN
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]      opcode;
    logic [DT_W-1:0]      delta_time;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] target_y;
    logic signed [CW-1:0] target_z;
  } in_req_t;

  typedef struct packed {
    logic signed [CW-1:0]  pos_x;
    logic signed [CW-1:0]  pos_y;
    logic signed [CW-1:0]  pos_z;
    logic [ALPHA_W-1:0]    blend;
  } out_rsp_t;

endpackage
`default_nettype wire

@@ hdl/ease_in_vec3_interpolator_top.sv @@
// ease-in 3d interpolator: sequencer around one shared multiplier, root and divide steps
//
// Each request carries an opcode: tick grows alpha by rate * factor * delta_time,
// where factor is the remaining distance to the target over the start-to-target
// span (floored at 0.1, span floored at one lsb), saturates alpha at 1.0 and
// moves the position to lerp(start, target, alpha). Retarget makes the current
// position the new start, loads the new target and measures the span. Clear
// zeroes alpha; opcode 3 only reports. Every request returns position and alpha.
// One request is taken at a time. A tick runs the 33-step square root, the
// 49-step restoring divide and the 11 passes through the shared 32x32
// multiplier (three squares, rate*dt, four partial products, three lerp
// products), each a multiply step and an add or load step, plus an alpha
// update step; a retarget runs only the three squares and the square root,
// and clear and no-op go straight to the final step. A result that is not
// taken holds the sequencer in its final step until the output register
// frees up.
// The result sits in an output register, so a new request can be taken while the
// previous result waits. alpha_rate is register 0 at byte address 0.
`default_nettype none
`include "assert_macros.svh"
module ease_in_vec3_interpolator_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire eiv3_pkg::in_req_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output eiv3_pkg::out_rsp_t             out_data,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [eiv3_pkg::ADDR_W-1:0] paddr,
  input  wire logic [eiv3_pkg::DATA_W-1:0] pwdata,
  output logic [eiv3_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import eiv3_pkg::*;

  // control
  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic [1:0]       idx_r;
  logic [CNT_W-1:0] cnt_r;
  op_e              op_r;
  logic [DT_W-1:0]  dt_r;

  // architectural state
  logic [RATE_W-1:0]    rate_r;
  logic signed [CW-1:0] pos_r   [3];
  logic signed [CW-1:0] start_r [3];
  logic signed [CW-1:0] tgt_r   [3];
  logic [ALPHA_W-1:0]   alpha_r;
  logic [DIST_W-1:0]    span_r;

  // working registers
  logic [2*MUL_W-1:0] mul_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SREM_W-1:0]  srem_r;
  logic [DIST_W-1:0]  root_r;
  logic [FACT_W-1:0]  dq_r;
  logic [DIST_W-1:0]  drem_r;
  logic [FACT_W-1:0]  fact_r;
  logic [RD_W-1:0]    rd_r;
  logic [ACC_W-1:0]   acc_r;
  out_rsp_t           out_r;

  logic accept, wr_en, out_load;
  assign accept   = in_valid && in_ready;
  assign wr_en    = psel && penable && pwrite && pready;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == REG_ALPHA_RATE) begin
      prdata = DATA_W'(rate_r);
    end else begin
      prdata = '0;
    end
  end

  // current-to-target difference for the squares
  logic signed [CW:0] sq_dif;
  logic [CW-1:0]      sq_mag;
  assign sq_dif = {pos_r[idx_r][CW-1], pos_r[idx_r]} - {tgt_r[idx_r][CW-1], tgt_r[idx_r]};
  assign sq_mag = sq_dif[CW] ? CW'(-sq_dif) : sq_dif[CW-1:0];

  // start-to-target difference for the lerp
  logic signed [CW:0] lp_dif;
  logic [CW-1:0]      lp_mag;
  assign lp_dif = {tgt_r[idx_r][CW-1], tgt_r[idx_r]} - {start_r[idx_r][CW-1], start_r[idx_r]};
  assign lp_mag = lp_dif[CW] ? CW'(-lp_dif) : lp_dif[CW-1:0];

  // shared multiplier operand select
  logic [MUL_W-1:0] mul_a, mul_b;
  always_comb begin
    case (state_r)
      ST_SQ_MUL: begin
        mul_a = sq_mag;
        mul_b = sq_mag;
      end
      ST_RATE_MUL: begin
        mul_a = MUL_W'(rate_r);
        mul_b = MUL_W'(dt_r);
      end
      ST_PP_MUL: begin
        mul_a = idx_r[0] ? MUL_W'(rd_r[RD_W-1:MUL_W]) : rd_r[MUL_W-1:0];
        mul_b = idx_r[1] ? MUL_W'(fact_r[FACT_W-1:MUL_W]) : fact_r[MUL_W-1:0];
      end
      ST_LERP_MUL: begin
        mul_a = lp_mag;
        mul_b = MUL_W'(alpha_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // square root step, two radicand bits per cycle
  logic [SREM_W-1:0] srem_s, trial;
  logic              sge;
  logic [DIST_W-1:0] root_new;
  assign srem_s   = {srem_r[SREM_W-3:0], sum_r[SUM_W-1 -: 2]};
  assign trial    = SREM_W'({root_r, 2'b01});
  assign sge      = srem_s >= trial;
  assign root_new = {root_r[DIST_W-2:0], sge};

  // restoring divide step
  logic [DIST_W-1:0] divisor;
  logic [DIST_W:0]   drem_s;
  logic              dge;
  logic [FACT_W-1:0] q_new, fact_clamp;
  assign divisor = (span_r == '0) ? DIST_W'(1) : span_r;
  assign drem_s  = {drem_r, dq_r[FACT_W-1]};
  assign dge     = drem_s >= {1'b0, divisor};
  assign q_new   = {dq_r[FACT_W-2:0], dge};
  always_comb begin
    if (q_new > FACTOR_CAP) begin
      fact_clamp = FACTOR_CAP;
    end else if (q_new < FACTOR_FLOOR) begin
      fact_clamp = FACTOR_FLOOR;
    end else begin
      fact_clamp = q_new;
    end
  end

  // partial product placement
  logic [ACC_W-1:0] pp_sh;
  always_comb begin
    case (idx_r)
      2'd0:    pp_sh = ACC_W'(mul_r);
      2'd3:    pp_sh = ACC_W'(mul_r) << (2 * MUL_W);
      default: pp_sh = ACC_W'(mul_r) << MUL_W;
    endcase
  end

  // alpha increment with saturation
  logic [INC_W-1:0]   inc;
  logic [ALPHA_W-1:0] headroom, alpha_new;
  assign inc      = INC_W'(acc_r >> INC_SH);
  assign headroom = ALPHA_ONE - alpha_r;
  assign alpha_new = (inc >= INC_W'(headroom)) ? ALPHA_ONE : alpha_r + inc[ALPHA_W-1:0];

  // lerp result, floor toward minus infinity
  logic [CW-1:0] lq;
  logic          lrem;
  logic signed [CW-1:0] lerp_new;
  assign lq   = CW'(mul_r >> AF);
  assign lrem = |mul_r[AF-1:0];
  assign lerp_new = lp_dif[CW] ? start_r[idx_r] - lq - CW'(lrem) : start_r[idx_r] + lq;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.opcode == OP_TICK || in_data.opcode == OP_RETARGET) begin
            state_nxt = ST_SQ_MUL;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SQ_MUL: state_nxt = ST_SQ_ADD;
      ST_SQ_ADD: state_nxt = (idx_r == 2'd2) ? ST_SQRT : ST_SQ_MUL;
      ST_SQRT: begin
        if (cnt_r == CNT_W'(SQ_ITERS - 1)) begin
          state_nxt = (op_r == OP_RETARGET) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(FACT_W - 1)) begin
          state_nxt = ST_RATE_MUL;
        end
      end
      ST_RATE_MUL: state_nxt = ST_RATE_LD;
      ST_RATE_LD:  state_nxt = ST_PP_MUL;
      ST_PP_MUL:   state_nxt = ST_PP_ADD;
      ST_PP_ADD:   state_nxt = (idx_r == 2'd3) ? ST_INC : ST_PP_MUL;
      ST_INC:      state_nxt = ST_LERP_MUL;
      ST_LERP_MUL: state_nxt = ST_LERP_ADD;
      ST_LERP_ADD: state_nxt = (idx_r == 2'd2) ? ST_FIN : ST_LERP_MUL;
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // architectural state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_RESET;
      alpha_r <= '0;
      span_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i]   <= '0;
        start_r[i] <= '0;
        tgt_r[i]   <= '0;
      end
    end else begin
      if (wr_en && paddr[2] == REG_ALPHA_RATE) begin
        rate_r <= pwdata[RATE_W-1:0];
      end
      if (accept && in_data.opcode == OP_RETARGET) begin
        for (int i = 0; i < 3; i++) begin
          start_r[i] <= pos_r[i];
        end
        tgt_r[0] <= in_data.target_x;
        tgt_r[1] <= in_data.target_y;
        tgt_r[2] <= in_data.target_z;
      end
      if (accept && in_data.opcode == OP_CLEAR) begin
        alpha_r <= '0;
      end
      if (state_r == ST_SQRT && cnt_r == CNT_W'(SQ_ITERS - 1) && op_r == OP_RETARGET) begin
        span_r <= root_new;
      end
      if (state_r == ST_INC) begin
        alpha_r <= alpha_new;
      end
      if (state_r == ST_LERP_ADD) begin
        pos_r[idx_r] <= lerp_new;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        op_r  <= op_e'(in_data.opcode);
        dt_r  <= in_data.delta_time;
        sum_r <= '0;
        idx_r <= '0;
      end
      ST_SQ_ADD: begin
        sum_r  <= sum_r + SUM_W'(mul_r);
        idx_r  <= idx_r + 2'd1;
        cnt_r  <= '0;
        srem_r <= '0;
        root_r <= '0;
      end
      ST_SQRT: begin
        srem_r <= sge ? srem_s - trial : srem_s;
        root_r <= root_new;
        sum_r  <= sum_r << 2;
        cnt_r  <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SQ_ITERS - 1)) begin
          dq_r   <= {root_new, FQ'(0)};
          drem_r <= '0;
          cnt_r  <= '0;
        end
      end
      ST_DIV: begin
        drem_r <= dge ? DIST_W'(drem_s - {1'b0, divisor}) : drem_s[DIST_W-1:0];
        dq_r   <= q_new;
        cnt_r  <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FACT_W - 1)) begin
          fact_r <= fact_clamp;
        end
      end
      ST_RATE_LD: begin
        rd_r  <= mul_r[RD_W-1:0];
        acc_r <= '0;
        idx_r <= '0;
      end
      ST_PP_ADD: begin
        acc_r <= acc_r + pp_sh;
        idx_r <= idx_r + 2'd1;
      end
      ST_INC: begin
        idx_r <= '0;
      end
      ST_LERP_ADD: begin
        idx_r <= idx_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // output register, frees the input side while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.pos_x <= pos_r[0];
      out_r.pos_y <= pos_r[1];
      out_r.pos_z <= pos_r[2];
      out_r.blend <= alpha_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // alpha never passes 1.0
  `ASSERT_NOW(a_alpha_range, 1'b1, alpha_r <= ALPHA_ONE)
  // one request at a time
  `ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
  // factor inside its floor and cap when used
  `ASSERT_NOW(a_factor_range, state_r == ST_RATE_MUL,
              fact_r >= FACTOR_FLOOR && fact_r <= FACTOR_CAP)
  // a result appears only from the final step
  `ASSERT_NEXT(a_result_source, !out_valid_r && state_r != ST_FIN, !out_valid_r)

endmodule
`default_nettype wire
